// ----- rtl/core/meter_frame_deframer_assert.svh -----
// assertion macros for the meter frame deframer
`ifndef METER_FRAME_DEFRAMER_ASSERT_SVH
`define METER_FRAME_DEFRAMER_ASSERT_SVH

// property checked outside reset
`define MFD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deframer assertion failed");

// property checked at every edge, reset included
`define MFD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("deframer assertion failed");

`endif

// ----- rtl/core/mfd_pkg.sv -----
package mfd_pkg;

  // frame marker bytes and data bias
  localparam logic [7:0] StartMark = 8'h68;
  localparam logic [7:0] StopMark  = 8'h16;
  localparam logic [7:0] DataBias  = 8'h33;

  // history window and address span
  localparam int unsigned HistDepth = 7;
  localparam int unsigned AddrBytes = 6;

  // default depth of the queue between parser and output stage
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CONTROL,
    PH_LENGTH,
    PH_DATA,
    PH_CHECK,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_END = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    status_e     status;
    logic [4:0]  cmd_code;
    logic [47:0] station_address;
    logic [7:0]  data_length;
  } out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/mfd_front.sv -----
module mfd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mfd_pkg::in_t     in_data_i,
  input  mfd_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output mfd_pkg::out_t    push_data_o
);

  logic [7:0]      hist_q [mfd_pkg::HistDepth];
  logic [7:0]      hist_d [mfd_pkg::HistDepth];
  mfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      ctrl_q, ctrl_d;
  logic [47:0]     addr_q, addr_d;
  logic            match_q, match_d;

  logic            accept;
  logic            has_res;
  logic [7:0]      b;
  logic [7:0]      start_sum;
  logic [47:0]     start_addr;
  mfd_pkg::out_t   res;

  assign b          = in_data_i.rx_byte;
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  // checksum and address seen from the window when a start is found
  always_comb begin
    start_sum  = b;
    start_addr = '0;
    for (int i = 0; i < mfd_pkg::HistDepth; i++) begin
      start_sum = start_sum + hist_q[i];
    end
    for (int i = 1; i <= mfd_pkg::AddrBytes; i++) begin
      start_addr[(i-1)*8 +: 8] = hist_q[i];
    end
  end

  // parser next state and result record
  always_comb begin
    hist_d  = hist_q;
    phase_d = phase_q;
    rem_d   = rem_q;
    len_d   = len_q;
    sum_d   = sum_q;
    ctrl_d  = ctrl_q;
    addr_d  = addr_q;
    match_d = match_q;
    has_res = 1'b0;

    res.kind            = mfd_pkg::KIND_DATA;
    res.data_byte       = b - mfd_pkg::DataBias;
    res.status          = mfd_pkg::ST_GOOD;
    res.cmd_code        = ctrl_q[4:0];
    res.station_address = addr_q;
    res.data_length     = len_q;

    case (phase_q)
      mfd_pkg::PH_HUNT: begin
        if (b == mfd_pkg::StartMark && hist_q[0] == mfd_pkg::StartMark) begin
          sum_d   = start_sum;
          addr_d  = start_addr;
          phase_d = mfd_pkg::PH_CONTROL;
        end else begin
          for (int i = 0; i < mfd_pkg::HistDepth - 1; i++) begin
            hist_d[i] = hist_q[i+1];
          end
          hist_d[mfd_pkg::HistDepth-1] = b;
        end
      end
      mfd_pkg::PH_CONTROL: begin
        ctrl_d  = b;
        sum_d   = sum_q + b;
        phase_d = mfd_pkg::PH_LENGTH;
      end
      mfd_pkg::PH_LENGTH: begin
        len_d   = b;
        rem_d   = b;
        sum_d   = sum_q + b;
        phase_d = (b == 8'd0) ? mfd_pkg::PH_CHECK : mfd_pkg::PH_DATA;
      end
      mfd_pkg::PH_DATA: begin
        sum_d   = sum_q + b;
        has_res = 1'b1;
        rem_d   = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          phase_d = mfd_pkg::PH_CHECK;
        end
      end
      mfd_pkg::PH_CHECK: begin
        match_d = (b == sum_q);
        phase_d = mfd_pkg::PH_STOP;
      end
      mfd_pkg::PH_STOP: begin
        has_res  = 1'b1;
        res.kind = mfd_pkg::KIND_DONE;
        if (b != mfd_pkg::StopMark) begin
          res.status = mfd_pkg::ST_BAD_END;
        end else if (!match_q) begin
          res.status = mfd_pkg::ST_BAD_SUM;
        end else begin
          res.status = mfd_pkg::ST_GOOD;
        end
        phase_d = mfd_pkg::PH_HUNT;
        hist_d  = '{default: 8'd0};
      end
      default: begin
        phase_d = mfd_pkg::PH_HUNT;
        hist_d  = '{default: 8'd0};
      end
    endcase

    // chunk end drops any unfinished frame and clears the history window
    if (in_data_i.buffer_end) begin
      if (phase_d != mfd_pkg::PH_HUNT) begin
        has_res  = 1'b1;
        res.kind = mfd_pkg::KIND_ABORT;
        phase_d  = mfd_pkg::PH_HUNT;
        rem_d    = 8'd0;
      end
      hist_d = '{default: 8'd0};
    end
  end

  assign push_o      = accept && has_res;
  assign push_data_o = res;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '{default: 8'd0};
      phase_q <= mfd_pkg::PH_HUNT;
      rem_q   <= 8'd0;
      len_q   <= 8'd0;
      sum_q   <= 8'd0;
      ctrl_q  <= 8'd0;
      addr_q  <= 48'd0;
      match_q <= 1'b0;
    end else if (accept) begin
      hist_q  <= hist_d;
      phase_q <= phase_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      ctrl_q  <= ctrl_d;
      addr_q  <= addr_d;
      match_q <= match_d;
    end
  end

endmodule

// ----- rtl/core/mfd_queue.sv -----
module mfd_queue #(
  parameter int unsigned Depth = mfd_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mfd_pkg::out_t    push_data_i,
  input  logic             pop_i,
  output mfd_pkg::q_stat_t stat_o,
  output mfd_pkg::out_t    head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mfd_pkg::out_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/mfd_back.sv -----
module mfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mfd_pkg::q_stat_t q_stat_i,
  input  mfd_pkg::out_t    head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mfd_pkg::out_t    out_data_o
);

  logic          valid_q, valid_d;
  mfd_pkg::out_t data_q;
  mfd_pkg::out_t fmt;

  // keep only the fields that belong to each kind of result
  always_comb begin
    fmt      = '0;
    fmt.kind = head_i.kind;
    case (head_i.kind)
      mfd_pkg::KIND_DATA: begin
        fmt.data_byte = head_i.data_byte;
      end
      mfd_pkg::KIND_DONE: begin
        fmt.status          = head_i.status;
        fmt.cmd_code        = (head_i.status == mfd_pkg::ST_GOOD) ? head_i.cmd_code : 5'd0;
        fmt.station_address = head_i.station_address;
        fmt.data_length     = head_i.data_length;
      end
      default: begin
        fmt.kind = mfd_pkg::KIND_ABORT;
      end
    endcase
  end

  // move a queued result to the output reg when free or drained
  assign pop_o = !q_stat_i.empty && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= fmt;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/core/meter_frame_deframer.sv -----
// channel | dir | handshake                  | payload
// --------+-----+----------------------------+----------------------
// in      | in  | in_valid_i / in_ready_o    | in_data_i  (in_t)
// out     | out | out_valid_o / out_ready_i  | out_data_o (out_t)
//
// one byte is taken every cycle while the result queue is not full; the parser updates its state on each byte taken
// a result is written into the queue when its byte is taken, then moved into the
// output register; either can hold it while the output stalls
// in_ready_o drops only while the result queue is full (output stalled)
// reset clears parser state, history window, queue pointers and count and the output valid flag at once

`include "meter_frame_deframer_assert.svh"

module meter_frame_deframer #(
  parameter int unsigned QueueDepth = mfd_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mfd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mfd_pkg::out_t out_data_o
);

  mfd_pkg::q_stat_t q_stat;
  logic             q_push, q_pop;
  mfd_pkg::out_t    q_push_data, q_head;

  // byte parser
  mfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  // result queue between parser and output stage
  mfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .stat_o      (q_stat),
    .head_o      (q_head)
  );

  // output stage
  mfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // checks
  `MFD_ASSERT_ALWAYS(a_no_push_when_full, clk_i, !(q_push && q_stat.full))
  `MFD_ASSERT(a_no_pop_when_empty, clk_i, rst_ni, q_pop |-> !q_stat.empty)
  `MFD_ASSERT(a_abort_fields_zero, clk_i, rst_ni,
    (out_valid_o && out_data_o.kind == mfd_pkg::KIND_ABORT) |->
      (out_data_o.station_address == 48'd0 && out_data_o.data_length == 8'd0 &&
       out_data_o.data_byte == 8'd0))
  `MFD_ASSERT(a_data_fields_zero, clk_i, rst_ni,
    (out_valid_o && out_data_o.kind == mfd_pkg::KIND_DATA) |->
      (out_data_o.station_address == 48'd0 && out_data_o.cmd_code == 5'd0 &&
       out_data_o.status == mfd_pkg::ST_GOOD))

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mfd_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  meter_frame_deframer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // deframer state as predicted
  logic [7:0] win [HistDepth] = '{default: 8'h00};
  phase_e ph = PH_HUNT;
  logic [7:0] left_cnt = 8'h00;
  logic [7:0] flen = 8'h00;
  logic [7:0] run_sum = 8'h00;
  logic [7:0] ctrl = 8'h00;
  logic [47:0] addr_acc = 48'h0;
  bit sum_ok = 1'b0;

  out_t pending_results[$];
  in_t byte_stream[$];
  logic [7:0] fixed_data[$];

  int errors = 0;
  int n_bytes = 0;
  int n_data = 0;
  int n_good = 0;
  int n_bad_end = 0;
  int n_bad_sum = 0;
  int n_abort = 0;
  int tx_max_gap = 16;
  int rx_max_gap = 16;
  int rx_hold_req = 0;

  // one byte through the predicted parser; returns 1 when a result is due
  function automatic bit deframe_byte(input in_t beat, output out_t res);
    logic [7:0] b;
    logic [7:0] s;
    status_e st;
    bit has;
    b = beat.rx_byte;
    has = 1'b0;
    res = '0;
    case (ph)
      PH_HUNT: begin
        if (b == StartMark && win[0] == StartMark) begin
          s = b;
          for (int i = 0; i < HistDepth; i++) s += win[i];
          run_sum = s;
          addr_acc = {win[6], win[5], win[4], win[3], win[2], win[1]};
          ph = PH_CONTROL;
        end else begin
          for (int i = 0; i < HistDepth - 1; i++) win[i] = win[i + 1];
          win[HistDepth - 1] = b;
        end
      end
      PH_CONTROL: begin
        ctrl = b;
        run_sum += b;
        ph = PH_LENGTH;
      end
      PH_LENGTH: begin
        flen = b;
        left_cnt = b;
        run_sum += b;
        ph = (b == 8'h00) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        run_sum += b;
        res.kind = KIND_DATA;
        res.data_byte = b - DataBias;
        has = 1'b1;
        left_cnt = left_cnt - 8'd1;
        if (left_cnt == 8'h00) ph = PH_CHECK;
      end
      PH_CHECK: begin
        sum_ok = (b == run_sum);
        ph = PH_STOP;
      end
      PH_STOP: begin
        // end marker wins over checksum
        if (b != StopMark) st = ST_BAD_END;
        else if (!sum_ok) st = ST_BAD_SUM;
        else st = ST_GOOD;
        res.kind = KIND_DONE;
        res.status = st;
        res.cmd_code = (st == ST_GOOD) ? ctrl[4:0] : 5'd0;
        res.station_address = addr_acc;
        res.data_length = flen;
        has = 1'b1;
        ph = PH_HUNT;
        foreach (win[i]) win[i] = 8'h00;
      end
      default: begin
        ph = PH_HUNT;
        foreach (win[i]) win[i] = 8'h00;
      end
    endcase
    // chunk end drops an unfinished frame and always clears the window
    if (beat.buffer_end) begin
      if (ph != PH_HUNT) begin
        res = '0;
        res.kind = KIND_ABORT;
        has = 1'b1;
        ph = PH_HUNT;
        left_cnt = 8'h00;
      end
      foreach (win[i]) win[i] = 8'h00;
    end
    return has;
  endfunction

  // one beat on the input channel, after a random gap
  task automatic send_beat(input in_t item);
    int gap;
    out_t res;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready);
    n_bytes++;
    if (deframe_byte(item, res)) pending_results.push_back(res);
  endtask

  task automatic send_stream();
    while (byte_stream.size() != 0) send_beat(byte_stream.pop_front());
  endtask

  // sender pauses until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // a whole frame; a chunk end at cut_at truncates the frame there
  task automatic add_frame(input logic [47:0] addr, input logic [7:0] ctl, input int len,
                           input bit bad_sum, input bit bad_stop, input int cut_at);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    int last;
    bytes.push_back(StartMark);
    for (int i = 0; i < AddrBytes; i++) bytes.push_back(addr[8*i +: 8]);
    bytes.push_back(StartMark);
    bytes.push_back(ctl);
    bytes.push_back(8'(len));
    for (int i = 0; i < len; i++)
      bytes.push_back(fixed_data.size() != 0 ? fixed_data.pop_front() : 8'($urandom));
    sum = 8'h00;
    foreach (bytes[i]) sum += bytes[i];
    bytes.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
    bytes.push_back(bad_stop ? StopMark + 8'($urandom_range(1, 255)) : StopMark);
    last = (cut_at >= 0) ? cut_at : bytes.size() - 1;
    for (int i = 0; i <= last; i++)
      byte_stream.push_back(in_t'{rx_byte: bytes[i], buffer_end: 1'(i == cut_at)});
  endtask

  task automatic add_noise(input int n, input int end_pct);
    for (int i = 0; i < n; i++)
      byte_stream.push_back(in_t'{rx_byte: 8'($urandom),
                                  buffer_end: 1'($urandom_range(0, 99) < end_pct)});
  endtask

  // extremes and corner cases, each a single frame or byte
  task automatic test_directed_cases();
    // zero length with bad checksum and bad end marker
    add_frame(48'h0, 8'hff, 0, 1'b1, 1'b1, -1);
    // chunk end while hunting
    byte_stream.push_back(in_t'{rx_byte: StartMark, buffer_end: 1'b1});
    // chunk end on the byte that opens the frame
    add_frame(48'h0102_0304_0506, 8'h11, 3, 1'b0, 1'b0, 7);
    // good frame, data extremes, chunk end on its last byte
    fixed_data = '{8'h00, 8'hff};
    add_frame(48'hffff_ffff_ffff, 8'he5, 2, 1'b0, 1'b0, 13);
    send_stream();
    wait_drained();
  endtask

  // mostly well formed frames with random content, some broken or noise
  task automatic test_random_traffic(input int n_items);
    int target;
    int len;
    target = n_bytes + n_items;
    while (n_bytes < target) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else begin
        tx_max_gap = 16;
        rx_max_gap = 16;
      end
      if ($urandom_range(0, 99) < 10) begin
        add_noise($urandom_range(1, 6), 15);
      end else begin
        add_noise($urandom_range(0, 2), 0);
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        add_frame({16'($urandom), 32'($urandom)}, 8'($urandom), len,
                  $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12,
                  ($urandom_range(0, 99) < 12) ? $urandom_range(0, len + 11) : -1);
      end
      send_stream();
    end
    tx_max_gap = 16;
    rx_max_gap = 16;
    wait_drained();
  endtask

  // receiver holds off while the sender streams at full rate
  task automatic test_output_backpressure();
    tx_max_gap = 0;
    rx_hold_req = HoldCycles;
    add_frame({16'($urandom), 32'($urandom)}, 8'($urandom), 40, 1'b0, 1'b0, -1);
    send_stream();
    wait_drained();
    tx_max_gap = 16;
  endtask

  task automatic test_longest_frame();
    add_frame({16'($urandom), 32'($urandom)}, 8'($urandom), 255, 1'b0, 1'b0, -1);
    send_stream();
    wait_drained();
  endtask

  // receiver: random stall per beat, or one long hold when asked
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = $urandom_range(0, rx_max_gap);
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    out_t exp;
    out_t got;
    if (rst_ni && out_valid && out_ready) begin
      got = out_data;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (got.kind !== exp.kind) begin
          $error("kind: expected %0d, got %0d", exp.kind, got.kind);
          errors++;
        end
        if (got.data_byte !== exp.data_byte) begin
          $error("data_byte: expected %h, got %h", exp.data_byte, got.data_byte);
          errors++;
        end
        if (got.status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, got.status);
          errors++;
        end
        if (got.cmd_code !== exp.cmd_code) begin
          $error("cmd_code: expected %h, got %h", exp.cmd_code, got.cmd_code);
          errors++;
        end
        if (got.station_address !== exp.station_address) begin
          $error("station_address: expected %h, got %h",
                 exp.station_address, got.station_address);
          errors++;
        end
        if (got.data_length !== exp.data_length) begin
          $error("data_length: expected %h, got %h", exp.data_length, got.data_length);
          errors++;
        end
        case (exp.kind)
          KIND_DATA:  n_data++;
          KIND_ABORT: n_abort++;
          default: begin
            if (exp.status == ST_GOOD) n_good++;
            else if (exp.status == ST_BAD_END) n_bad_end++;
            else n_bad_sum++;
          end
        endcase
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    int idle;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
    else idle++;
    if (idle >= IdleLimit) begin
      $display("no progress for %0d cycles", IdleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic(60);
    test_output_backpressure();
    test_longest_frame();
    test_random_traffic(40);

    wait_drained();
    repeat (6) @(posedge clk_i);
    $display("bytes sent %0d: data %0d, frames good %0d, bad end %0d, bad sum %0d",
             n_bytes, n_data, n_good, n_bad_end, n_bad_sum);
    $display("abandoned frames %0d, mismatches %0d", n_abort, errors);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mfd_pkg.sv
rtl/core/mfd_front.sv
rtl/core/mfd_queue.sv
rtl/core/mfd_back.sv
rtl/core/meter_frame_deframer.sv
verif/tb_top.sv
